/* sv/h2r_pkg.sv */
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types, constants and helpers of the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package h2r_pkg;

  // Chain length; an index at or above it is rejected.
  localparam int unsigned NUM_LEDS = 256;
  localparam logic [16:0] NumLedsW = 17'(NUM_LEDS);

  localparam logic [10:0] HUE_LIMIT  = 11'd1536;
  localparam logic [8:0]  FULL_LEVEL = 9'd255;

  // Hue sectors (hue / 256)
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;

  typedef struct packed {
    logic [7:0]  led_index;
    logic [10:0] hue;
    logic [8:0]  saturation;
    logic [8:0]  brightness;
  } in_t;

  typedef struct packed {
    logic [7:0] led_out;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       write_enable;
  } out_t;

  // Fields carried along every stage
  typedef struct packed {
    logic       valid;
    logic [7:0] led;
    logic       we;
    logic       grey;
    logic [2:0] sector;
    logic [7:0] val;
  } ctl_t;

  // After the first multiply
  typedef struct packed {
    ctl_t        ctl;
    logic [15:0] p_lo;
    logic [15:0] p_up;
    logic [15:0] p_dn;
  } s1_t;

  // After the first divide
  typedef struct packed {
    ctl_t       ctl;
    logic [7:0] lo;
    logic [7:0] q_up;
    logic [7:0] q_dn;
  } s2_t;

  // After the second multiply
  typedef struct packed {
    ctl_t        ctl;
    logic [7:0]  lo;
    logic [15:0] p_up;
    logic [15:0] p_dn;
  } s3_t;

  // Truncating x / 255, exact for any product of two 8-bit levels.
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

/* sv/h2r_in_if.sv */
// ----------------------------------------------------------------------------
// h2r_in_if
// Valid/ready channel carrying one HSV request per transaction.
// ----------------------------------------------------------------------------
interface h2r_in_if;
  logic         valid;
  logic         ready;
  h2r_pkg::in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/h2r_out_if.sv */
// ----------------------------------------------------------------------------
// h2r_out_if
// Valid/ready channel carrying one RGB result per transaction.
// ----------------------------------------------------------------------------
interface h2r_out_if;
  logic          valid;
  logic          ready;
  h2r_pkg::out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/h2r_front.sv */
// ----------------------------------------------------------------------------
// h2r_front
// Stages 1 and 2: range checks and first products, then division by 255.
// ----------------------------------------------------------------------------
module h2r_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  h2r_pkg::in_t   data_i,
  output h2r_pkg::s2_t   s2_o
);

  h2r_pkg::s1_t s1_d, s1_q;
  h2r_pkg::s2_t s2_d, s2_q;

  logic [7:0] sat8, rem8;

  always_comb begin
    sat8 = data_i.saturation[7:0];
    rem8 = data_i.hue[7:0];
    s1_d.ctl.valid  = valid_i;
    s1_d.ctl.led    = data_i.led_index;
    s1_d.ctl.we     = (data_i.hue < h2r_pkg::HUE_LIMIT)
                   && (data_i.saturation <= h2r_pkg::FULL_LEVEL)
                   && (data_i.brightness <= h2r_pkg::FULL_LEVEL)
                   && ({9'd0, data_i.led_index} < h2r_pkg::NumLedsW);
    s1_d.ctl.grey   = (sat8 == 8'd0);
    s1_d.ctl.sector = data_i.hue[10:8];
    s1_d.ctl.val    = data_i.brightness[7:0];
    s1_d.p_lo = 16'(data_i.brightness[7:0]) * 16'(8'd255 - sat8);
    s1_d.p_up = 16'(sat8) * 16'(rem8);
    s1_d.p_dn = 16'(sat8) * 16'(8'd255 - rem8);
  end

  always_comb begin
    s2_d.ctl  = s1_q.ctl;
    s2_d.lo   = h2r_pkg::div255(s1_q.p_lo);
    s2_d.q_up = h2r_pkg::div255(s1_q.p_up);
    s2_d.q_dn = h2r_pkg::div255(s1_q.p_dn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

  // An out-of-range hue never reaches stage 1 flagged for writing.
  a_hue_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && valid_i && (data_i.hue >= h2r_pkg::HUE_LIMIT) |=> !s1_q.ctl.we)
    else $error("out-of-range hue marked for write");

  // The minimum level never exceeds the value level.
  a_lo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q.ctl.valid && s2_q.ctl.we |-> s2_q.lo <= s2_q.ctl.val)
    else $error("min level above value");

endmodule

/* sv/h2r_back.sv */
// ----------------------------------------------------------------------------
// h2r_back
// Stages 3 and 4: scale by value, divide by 255, assign levels by sector.
// ----------------------------------------------------------------------------
module h2r_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  h2r_pkg::s2_t  s2_i,
  output logic          valid_o,
  output h2r_pkg::out_t data_o
);

  h2r_pkg::s3_t  s3_d, s3_q;
  h2r_pkg::out_t out_d, out_q;
  logic          valid_q;

  logic [7:0] hi, lo, up, dn;
  logic [7:0] r, g, b;

  always_comb begin
    s3_d.ctl  = s2_i.ctl;
    s3_d.lo   = s2_i.lo;
    s3_d.p_up = 16'(s2_i.ctl.val) * 16'(s2_i.q_up);
    s3_d.p_dn = 16'(s2_i.ctl.val) * 16'(s2_i.q_dn);
  end

  always_comb begin
    hi = s3_q.ctl.val;
    lo = s3_q.lo;
    up = h2r_pkg::div255(s3_q.p_up);
    dn = h2r_pkg::div255(s3_q.p_dn);
    unique case (s3_q.ctl.sector)
      h2r_pkg::SEC_RED_YEL: begin r = hi; g = up; b = lo; end
      h2r_pkg::SEC_YEL_GRN: begin r = dn; g = hi; b = lo; end
      h2r_pkg::SEC_GRN_CYN: begin r = lo; g = hi; b = up; end
      h2r_pkg::SEC_CYN_BLU: begin r = lo; g = dn; b = hi; end
      h2r_pkg::SEC_BLU_MAG: begin r = up; g = lo; b = hi; end
      default:              begin r = hi; g = lo; b = dn; end
    endcase
    if (s3_q.ctl.grey) begin
      r = hi;
      g = hi;
      b = hi;
    end
    if (!s3_q.ctl.we) begin
      r = 8'd0;
      g = 8'd0;
      b = 8'd0;
    end
    out_d.led_out      = s3_q.ctl.led;
    out_d.red          = r;
    out_d.green        = g;
    out_d.blue         = b;
    out_d.write_enable = s3_q.ctl.we;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q    <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      s3_q    <= s3_d;
      valid_q <= s3_q.ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

endmodule

/* sv/hsv_to_rgb_integer.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_integer
// Integer HSV to 8-bit RGB converter for an addressable LED chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one request per transaction: LED index, hue (0..1535 in six
//         sectors of 256), saturation and brightness (0..255 each).
//   out_o returns one result per request, in order: the index, red, green,
//         blue and write_enable. Out-of-range fields give write_enable = 0
//         and black; the index is always passed through.
//   Four register stages: a result is valid on out_o after its input
//   transaction has passed multiply, divide by 255, multiply by value, divide
//   and sector select. Throughput is one item per cycle while out_o is not
//   stalled with a result waiting.
//   The whole pipeline advances together: when out_o is stalled with a
//   result waiting, every stage holds and in_i.ready drops, so nothing is
//   lost or repeated. Empty stages are filled as long as out_o is free.
//   Reset clears all stage valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_integer (
  input  logic       clk_i,
  input  logic       rst_ni,
  h2r_in_if.sink     in_i,
  h2r_out_if.source  out_o
);

  logic         adv;
  h2r_pkg::s2_t s2;
  logic         out_valid;

  assign adv      = !out_valid || out_o.ready;
  assign in_i.ready = adv;

  h2r_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .data_i  (in_i.payload),
    .s2_o    (s2)
  );

  h2r_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .s2_i    (s2),
    .valid_o (out_valid),
    .data_o  (out_o.payload)
  );

  assign out_o.valid = out_valid;

  // A rejected request always reports black.
  a_reject_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_o.payload.write_enable |->
      (out_o.payload.red == 8'd0) && (out_o.payload.green == 8'd0)
      && (out_o.payload.blue == 8'd0))
    else $error("rejected request with nonzero color");

  // A stalled result is not dropped by the pipeline.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_o.ready |=> out_valid)
    else $error("result dropped during stall");

  // The input side is held off exactly while a result is stalled.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_valid && !out_o.ready)
    else $error("input stalled without output stall");

endmodule
